FILE: rtl/bmdr_pkg.sv
// Shared types and constants for the bicycle-model dead-reckoning block.
// Item structs, unit request structs and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package bmdr_pkg;

    typedef struct packed {
        logic signed [15:0] speed_mm_s;
        logic signed [15:0] steer_angle;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic        [31:0] heading;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_z;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        start;
        logic [31:0] ang;
    } cor_req_t;

    localparam int          REG_IDX_W     = 1;
    localparam int          CFG_DATA_W    = 20;
    localparam logic [0:0]  REG_STEP_TIME = 1'b0;
    localparam logic [0:0]  REG_WHEELBASE = 1'b1;

    localparam logic [19:0] DT_RESET = 20'd33333;
    localparam logic [15:0] WB_RESET = 16'd2789;

    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE         = 34'sd1073741824;
    localparam logic [36:0]        STEER_TO_TURN   = 37'd2734261102;
    localparam logic [30:0]        HEAD_SCALE      = 31'd358385071;
    // 1e9 = 2^9 * 5^9; distance rounding bias after the 2^9 is taken out
    localparam logic [20:0]        DIV_5_9         = 21'd1953125;
    localparam logic [30:0]        RCP_5_9         = 31'd1152921504;   // floor(2^51 / 5^9)
    localparam logic [50:0]        D24_BIAS        = 51'd976562;
    localparam logic signed [49:0] POS_MAX         = 50'sd140737488355327;
    localparam logic signed [49:0] POS_MIN         = -50'sd140737488355328;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10679838;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            5'd20:   r = 30'd652;
            5'd21:   r = 30'd326;
            5'd22:   r = 30'd163;
            5'd23:   r = 30'd81;
            5'd24:   r = 30'd41;
            5'd25:   r = 30'd20;
            5'd26:   r = 30'd10;
            5'd27:   r = 30'd5;
            5'd28:   r = 30'd3;
            5'd29:   r = 30'd1;
            5'd30:   r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bmdr_cordic.sv
// Iterative CORDIC rotator: one micro-rotation per cycle, cos/sin in Q30.
// Depends on bmdr_pkg (request struct, gain and arctangent table).
`default_nettype none

module bmdr_cordic #(
    parameter int ITERS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bmdr_pkg::cor_req_t req,
    output logic                    busy,
    output logic signed [33:0]      cos_out,
    output logic signed [33:0]      sin_out
);
    import bmdr_pkg::*;

    localparam logic [4:0] LAST_IDX = 5'(ITERS - 1);

    logic              busy_reg, busy_next;
    logic [4:0]        idx_reg, idx_next;
    logic              flip_reg, flip_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [33:0] cos_reg, cos_next, sin_reg, sin_next;
    logic signed [33:0] z0, xs, ys, at;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        z0 = {{2{req.ang[31]}}, req.ang};
        xs = x_reg >>> idx_reg;
        ys = y_reg >>> idx_reg;
        at = {4'd0, atan_turn(idx_reg)};
        if (!busy_reg)
        begin
            if (req.start)
            begin
                // fold into +-quarter turn, negate at the end
                busy_next = 1'b1;
                idx_next  = 5'd0;
                x_next    = CORDIC_GAIN_INV;
                y_next    = '0;
                if (z0 > 34'sd1073741824)
                begin
                    z_next    = z0 - 34'sd2147483648;
                    flip_next = 1'b1;
                end
                else if (z0 < -34'sd1073741824)
                begin
                    z_next    = z0 + 34'sd2147483648;
                    flip_next = 1'b1;
                end
                else
                begin
                    z_next    = z0;
                    flip_next = 1'b0;
                end
            end
        end
        else
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            idx_next = idx_reg + 5'd1;
            if (idx_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
                cos_next  = flip_reg ? -x_next : x_next;
                sin_next  = flip_reg ? -y_next : y_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            flip_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            flip_reg <= flip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    assign busy    = busy_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

`default_nettype wire

FILE: rtl/bmdr_div.sv
// Radix-2 restoring divider, 64-bit numerator by 32-bit divisor.
// Depends on bmdr_pkg (request struct).
`default_nettype none

module bmdr_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bmdr_pkg::div_req_t req,
    output logic                    busy,
    output logic [63:0]             quot
);
    import bmdr_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] n_reg, n_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] trial, diff;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        trial = {rem_reg, n_reg[63]};
        diff  = trial - {1'b0, d_reg};
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                cnt_next  = '0;
                n_next    = req.num;
                d_next    = req.den;
                rem_next  = '0;
            end
        end
        else
        begin
            // quotient bits shift in where numerator bits leave
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                n_next   = {n_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                n_next   = {n_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign quot = n_reg;

endmodule

`default_nettype wire

FILE: rtl/bicycle_model_dead_reckoning.sv
// Kinematic bicycle-model dead reckoning: one item per speed/steer sample.
// A new item is accepted only once the previous result is registered; each
// item uses the shared multiplier, two divider passes (tangent, heading step)
// and three CORDIC passes, and its result waits while the one before it has
// not yet been taken through out_ready. Async active-low reset clears
// position, heading, handshakes, and loads the default time step (33333 us)
// and wheelbase (2789 mm).
`default_nettype none

module bicycle_model_dead_reckoning #(
    parameter int CORDIC_ITERS = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire bmdr_pkg::in_item_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output bmdr_pkg::out_item_t                     out_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [bmdr_pkg::REG_IDX_W-1:0]     cfg_index,
    input  wire logic [bmdr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bmdr_pkg::*;

    // Sequencer: states that drive the shared multiplier, divider or CORDIC, with wait and capture steps.
    typedef enum logic [4:0] {
        S_IDLE, S_MUL_A, S_MUL_S, S_START1, S_RCP_L, S_RCP_Q, S_RCP_M, S_RCP_C,
        S_WAIT1, S_MOVX, S_ADDX, S_ADDY, S_WAIT_SC, S_WAIT_TQ, S_MUL_P, S_DIV_Q,
        S_WAIT_Q, S_MUL_H, S_MUL_L, S_HEAD, S_WAIT_QT
    } state_t;

    state_t             state_reg, state_next;
    logic [19:0]        dt_reg;
    logic [15:0]        wb_reg;
    logic signed [15:0] speed_reg, speed_next, steer_reg, steer_next;
    logic [35:0]        a_reg, a_next;           // |v| * dt
    logic [31:0]        sturn_reg, sturn_next;   // steer angle in turns
    logic [31:0]        d24_reg, d24_next;       // distance, 2^-24 m
    logic signed [33:0] c_reg, c_next, s_reg, s_next;
    logic [30:0]        tq_reg, tq_next;         // tan(steer), Q20
    logic [56:0]        q_reg, q_next;
    logic [63:0]        hi_reg, hi_next;
    logic [67:0]        prod_reg, prod_next;
    logic signed [49:0] x_reg, x_next, y_reg, y_next;
    logic [31:0]        heading_reg, heading_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;

    // shared multiplier operands
    logic [36:0] mul_a;
    logic [30:0] mul_b;

    div_req_t           div_req;
    cor_req_t           cor_req;
    logic               div_busy, cor_busy;
    logic [63:0]        div_q;
    logic signed [33:0] cor_cos, cor_sin;

    // per-item derived values
    logic               vneg, sneg;
    logic [15:0]        av;
    logic signed [15:0] st_sat;
    logic [14:0]        ast;
    logic signed [33:0] c_abs, s_abs, sc, ay;
    logic [47:0]        ast_sum;
    logic [31:0]        ast_t;
    logic [15:0]        wb_eff;
    logic [49:0]        lo_sum;
    logic [63:0]        hsum;
    logic [31:0]        dh;
    logic [50:0]        m_val;       // a * 2^15 + bias, divided by 5^9 for d24
    logic [56:0]        rcp_sum;
    logic [50:0]        rem_val;

    // round(d24*|trig| / 2^38) half away from zero, sign applied afterwards
    function automatic logic signed [49:0] move_delta(input logic [67:0] p,
                                                       input logic neg);
        logic [61:0] t;
        logic signed [49:0] r;
        t = p[61:0] + (62'd1 << 37);
        r = {26'd0, t[61:38]};
        return neg ? -r : r;
    endfunction

    function automatic logic signed [49:0] sat_add(input logic signed [49:0] acc,
                                                    input logic signed [49:0] d);
        logic signed [49:0] r;
        r = acc + d;
        if (r > POS_MAX)
            return POS_MAX;
        if (r < POS_MIN)
            return POS_MIN;
        return r;
    endfunction

    function automatic logic signed [31:0] sat30(input logic signed [33:0] v);
        if (v > Q30_ONE)
            return 32'sd1073741824;
        if (v < -Q30_ONE)
            return -32'sd1073741824;
        return v[31:0];
    endfunction

    bmdr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quot  (div_q)
    );

    bmdr_cordic #(
        .ITERS (CORDIC_ITERS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (cor_req),
        .busy    (cor_busy),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    always_comb
    begin
        vneg   = speed_reg[15];
        av     = 16'(vneg ? -speed_reg : speed_reg);
        // steering saturates at +-1 rad
        if (steer_reg > 16'sd16384)
            st_sat = 16'sd16384;
        else if (steer_reg < -16'sd16384)
            st_sat = -16'sd16384;
        else
            st_sat = steer_reg;
        sneg    = st_sat[15];
        ast     = 15'(sneg ? -st_sat : st_sat);
        c_abs   = c_reg[33] ? -c_reg : c_reg;
        s_abs   = s_reg[33] ? -s_reg : s_reg;
        sc      = (cor_cos < 34'sd1) ? 34'sd1 : cor_cos;
        ay      = cor_sin[33] ? -cor_sin : cor_sin;
        ast_sum = prod_reg[47:0] + 48'd32768;
        ast_t   = ast_sum[47:16];
        wb_eff  = (wb_reg == 16'd0) ? 16'd1 : wb_reg;   // zero wheelbase -> 1 mm
        lo_sum  = prod_reg[49:0] + (50'd1 << 19);
        hsum    = hi_reg + {34'd0, lo_sum[49:20]} + (64'd1 << 19);
        dh      = hsum[51:20];
        // round(a*2^24/1e9) == floor((a*2^15 + 976562) / 5^9); m stays below 2^50
        m_val   = {a_reg, 15'd0} + D24_BIAS;
        // floor(m * R / 2^51) from the two partial products, at most one short
        rcp_sum = hi_reg[56:0] + {26'd0, prod_reg[55:25]};
        rem_val = m_val - prod_reg[50:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        speed_next     = speed_reg;
        steer_next     = steer_reg;
        a_next         = a_reg;
        sturn_next     = sturn_reg;
        d24_next       = d24_reg;
        c_next         = c_reg;
        s_next         = s_reg;
        tq_next        = tq_reg;
        q_next         = q_reg;
        hi_next        = hi_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        heading_next   = heading_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_req        = '0;
        cor_req        = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    speed_next = in_data.speed_mm_s;
                    steer_next = in_data.steer_angle;
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                mul_a      = {21'd0, av};
                mul_b      = {11'd0, dt_reg};
                state_next = S_MUL_S;
            end
            S_MUL_S:
            begin
                a_next     = prod_reg[35:0];
                mul_a      = STEER_TO_TURN;
                mul_b      = {16'd0, ast};
                state_next = S_START1;
            end
            S_START1:
            begin
                sturn_next = sneg ? (32'd0 - ast_t) : ast_t;
                // distance in 2^-24 m by reciprocal of 5^9, high half first
                mul_a      = {12'd0, m_val[49:25]};
                mul_b      = RCP_5_9;
                // position uses the heading from before this item
                cor_req.start = 1'b1;
                cor_req.ang   = {heading_reg[30:0], 1'b0};
                state_next    = S_RCP_L;
            end
            S_RCP_L:
            begin
                hi_next    = prod_reg[63:0];
                mul_a      = {12'd0, m_val[24:0]};
                mul_b      = RCP_5_9;
                state_next = S_RCP_Q;
            end
            S_RCP_Q:
            begin
                d24_next   = {1'b0, rcp_sum[56:26]};
                state_next = S_RCP_M;
            end
            S_RCP_M:
            begin
                mul_a      = {5'd0, d24_reg};
                mul_b      = {10'd0, DIV_5_9};
                state_next = S_RCP_C;
            end
            S_RCP_C:
            begin
                // estimate may be one low: bump if a whole divisor remains
                if (rem_val >= {30'd0, DIV_5_9})
                    d24_next = d24_reg + 32'd1;
                state_next = S_WAIT1;
            end
            S_WAIT1:
            begin
                if (!cor_busy)
                begin
                    c_next        = cor_cos;
                    s_next        = cor_sin;
                    cor_req.start = 1'b1;
                    cor_req.ang   = sturn_reg;
                    state_next    = S_MOVX;
                end
            end
            S_MOVX:
            begin
                mul_a      = {5'd0, d24_reg};
                mul_b      = c_abs[30:0];
                state_next = S_ADDX;
            end
            S_ADDX:
            begin
                x_next     = sat_add(x_reg, move_delta(prod_reg, vneg ^ c_reg[33]));
                mul_a      = {5'd0, d24_reg};
                mul_b      = s_abs[30:0];
                state_next = S_ADDY;
            end
            S_ADDY:
            begin
                y_next     = sat_add(y_reg, move_delta(prod_reg, vneg ^ s_reg[33]));
                state_next = S_WAIT_SC;
            end
            S_WAIT_SC:
            begin
                if (!cor_busy)
                begin
                    // tan = |sin| / cos in Q20, rounded
                    div_req.start = 1'b1;
                    div_req.num   = {10'd0, ay, 20'd0} + {31'd0, sc[33:1]};
                    div_req.den   = sc[31:0];
                    state_next    = S_WAIT_TQ;
                end
            end
            S_WAIT_TQ:
            begin
                if (!div_busy)
                begin
                    tq_next    = div_q[30:0];
                    state_next = S_MUL_P;
                end
            end
            S_MUL_P:
            begin
                mul_a      = {1'b0, a_reg};
                mul_b      = tq_reg;
                state_next = S_DIV_Q;
            end
            S_DIV_Q:
            begin
                div_req.start = 1'b1;
                div_req.num   = prod_reg[63:0] + {49'd0, wb_eff[15:1]};
                div_req.den   = {16'd0, wb_eff};
                state_next    = S_WAIT_Q;
            end
            S_WAIT_Q:
            begin
                if (!div_busy)
                begin
                    q_next     = div_q[56:0];
                    state_next = S_MUL_H;
                end
            end
            S_MUL_H:
            begin
                mul_a      = q_reg[56:20];
                mul_b      = HEAD_SCALE;
                state_next = S_MUL_L;
            end
            S_MUL_L:
            begin
                hi_next    = prod_reg[63:0];
                mul_a      = {17'd0, q_reg[19:0]};
                mul_b      = HEAD_SCALE;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                // heading wraps modulo 4*pi
                if (vneg != sneg)
                    heading_next = heading_reg - dh;
                else
                    heading_next = heading_reg + dh;
                cor_req.start = 1'b1;
                cor_req.ang   = heading_next;
                state_next    = S_WAIT_QT;
            end
            S_WAIT_QT:
            begin
                if (!cor_busy && (!out_valid_reg || out_ready))
                begin
                    out_next.pos_x   = x_reg[47:0];
                    out_next.pos_y   = y_reg[47:0];
                    out_next.heading = heading_reg;
                    out_next.quat_w  = sat30(cor_cos);
                    out_next.quat_z  = sat30(cor_sin);
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign prod_next = {31'd0, mul_a} * {37'd0, mul_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dt_reg        <= DT_RESET;
            wb_reg        <= WB_RESET;
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            heading_reg   <= heading_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_STEP_TIME: dt_reg <= cfg_data;
                    REG_WHEELBASE: wb_reg <= cfg_data[15:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg <= speed_next;
        steer_reg <= steer_next;
        a_reg     <= a_next;
        sturn_reg <= sturn_next;
        d24_reg   <= d24_next;
        c_reg     <= c_next;
        s_reg     <= s_next;
        tq_reg    <= tq_next;
        q_reg     <= q_next;
        hi_reg    <= hi_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // an accepted item makes the block busy, so in_ready is low straight after it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again straight after an accept");

    // the CORDIC must be running after the first launch
    a_units_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START1) |=> cor_busy)
        else $error("CORDIC failed to start");

    // heading only moves in the heading update step
    a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_HEAD) |=> $stable(heading_reg))
        else $error("heading changed outside its update step");

    // a result appears only on leaving the final CORDIC wait
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WAIT_QT))
        else $error("result raised from an unexpected state");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for bicycle_model_dead_reckoning: odometry steps, pose and quaternion.
// Drives valid/ready items and config writes, checks each result against an in-bench predictor.
// Depends on rtl/bmdr_pkg.sv and rtl/bicycle_model_dead_reckoning.sv.
`timescale 1ns / 100ps

module tb_top;
    import bmdr_pkg::*;

    localparam int  N_ROT      = 24;        // CORDIC iterations, as the DUT default
    localparam int  SETTLE     = 400;       // cycles waited after the last result, above block latency
    localparam longint LIMIT   = 4000000;   // watchdog, several times the slowest run
    localparam int  N_RANDOM   = 1700;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_wr_en;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bicycle_model_dead_reckoning dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: a private copy of the pose and the registers
    // ---------------------------------------------------------------
    bit [19:0]   dt_us;
    bit [15:0]   wb_mm;
    longint      pose_x, pose_y;
    bit [31:0]   pose_h;

    out_item_t   pose_q[$];        // expected poses, oldest first
    int          n_errors;
    int          n_sent;
    int          n_checked;
    int          n_cfg;
    longint      cycle_cnt;

    // arctan(2^-i) in 2^-32 turn
    longint atan_lut [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    // rotate (1/K, 0) by ang turns; cos and sin come back in Q30
    function automatic void rotate_unit(input bit [31:0] ang, output longint c,
                                        output longint s);
        longint x, y, z, nx;
        bit flip;
        x = 64'sd652032874;
        y = 0;
        z = longint'($signed(ang));
        flip = 1'b0;
        if (z > 64'sd1073741824)
        begin
            z = z - 64'sd2147483648;
            flip = 1'b1;
        end
        else if (z < -64'sd1073741824)
        begin
            z = z + 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < N_ROT; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_lut[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_lut[i];
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    // signed displacement: round(d24*|trig| / 2^38), sign from speed and trig
    function automatic longint displacement(input bit [63:0] d24, input longint trig,
                                            input bit vneg);
        bit [63:0] mag, r;
        mag = (trig < 0) ? -trig : trig;
        r = (d24 * mag + (64'd1 << 37)) >> 38;
        return (vneg != (trig < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > 64'sd140737488355327)  return 64'sd140737488355327;
        if (v < -64'sd140737488355328) return -64'sd140737488355328;
        return v;
    endfunction

    function automatic longint clamp_q30(input longint v);
        if (v > 64'sd1073741824)  return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    // advance the predicted pose by one sample, return the expected item
    function automatic out_item_t advance_pose(input in_item_t it);
        longint    v, st, c, s, sc, ss, ay;
        bit        vneg, sneg;
        bit [63:0] av, a, d24, wb, ast, tq, p, q, qh, ql, dh;
        bit [31:0] sturn;
        out_item_t r;
        v    = longint'(it.speed_mm_s);
        st   = longint'(it.steer_angle);
        vneg = v < 0;
        av   = vneg ? -v : v;
        a    = av * 64'(dt_us);
        d24  = ((a << 24) + 64'd500000000) / 64'd1000000000;
        wb   = (wb_mm != 0) ? 64'(wb_mm) : 64'd1;

        // move on the heading from before this sample
        rotate_unit(pose_h << 1, c, s);
        pose_x = clamp_pos(pose_x + displacement(d24, c, vneg));
        pose_y = clamp_pos(pose_y + displacement(d24, s, vneg));

        // steering saturates at one radian
        if (st > 16384)  st = 16384;
        if (st < -16384) st = -16384;
        sneg  = st < 0;
        ast   = sneg ? -st : st;
        ast   = (ast * 64'd2734261102 + 64'd32768) >> 16;
        sturn = sneg ? 32'(32'd0 - ast[31:0]) : ast[31:0];
        rotate_unit(sturn, sc, ss);
        if (sc < 1) sc = 1;
        ay = (ss < 0) ? -ss : ss;
        tq = ((64'(ay) << 20) + (64'(sc) >> 1)) / 64'(sc);

        p  = a * tq;
        q  = (p + (wb >> 1)) / wb;
        qh = q >> 20;
        ql = q & 64'hFFFFF;
        dh = (qh * 64'd358385071 + ((ql * 64'd358385071 + (64'd1 << 19)) >> 20)
              + (64'd1 << 19)) >> 20;
        if (vneg != sneg)
            pose_h = pose_h - dh[31:0];
        else
            pose_h = pose_h + dh[31:0];

        rotate_unit(pose_h, c, s);
        r.pos_x   = pose_x[47:0];
        r.pos_y   = pose_y[47:0];
        r.heading = pose_h;
        r.quat_w  = 32'(clamp_q30(c));
        r.quat_z  = 32'(clamp_q30(s));
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR item %0d: %s got %h want %h", n_checked, what, got, want);
        n_errors++;
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pose_q.size() == 0)
                report_mismatch("unexpected item", 64'(out_data.heading), 64'd0);
            else
            begin
                want = pose_q.pop_front();
                if (out_data.pos_x !== want.pos_x)
                    report_mismatch("pos_x", 64'(out_data.pos_x), 64'(want.pos_x));
                if (out_data.pos_y !== want.pos_y)
                    report_mismatch("pos_y", 64'(out_data.pos_y), 64'(want.pos_y));
                if (out_data.heading !== want.heading)
                    report_mismatch("heading", 64'(out_data.heading), 64'(want.heading));
                if (out_data.quat_w !== want.quat_w)
                    report_mismatch("quat_w", 64'(out_data.quat_w), 64'(want.quat_w));
                if (out_data.quat_z !== want.quat_z)
                    report_mismatch("quat_z", 64'(out_data.quat_z), 64'(want.quat_z));
            end
            n_checked++;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall pattern in modes, plus long hold-offs on request
    // ---------------------------------------------------------------
    int hold_reqs;       // bumped by a test to ask for a hold-off
    int hold_served;
    int hold_left;
    int sink_mode;
    int sink_mode_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            hold_served    = 0;
            hold_left      = 0;
            sink_mode      = 0;
            sink_mode_left = 0;
        end
        else
        begin
            if (hold_served != hold_reqs)
            begin
                hold_served = hold_reqs;
                hold_left   = 3000;
            end
            if (sink_mode_left == 0)
            begin
                sink_mode      = $urandom_range(0, 2);
                sink_mode_left = $urandom_range(50, 1500);
            end
            else
                sink_mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (sink_mode)
                    0:       out_ready <= 1'b1;                        // no stalls
                    1:       out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 3) == 0); // mostly stalled
                endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT)
        begin
            $display("watchdog expired after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sender: bursts of back-to-back items with random gaps between
    // ---------------------------------------------------------------
    int burst_left;

    task automatic send_item(input logic [15:0] spd, input logic [15:0] steer);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid           <= 1'b1;
        in_data.speed_mm_s  <= spd;
        in_data.steer_angle <= steer;
        do
            @(posedge clk);
        while (!in_ready);
        // item taken at this edge; valid stays up for a possible next item
        pose_q.push_back(advance_pose(in_item_t'({spd, steer})));
        n_sent++;
    endtask

    // drop valid at the last accept edge, wait for every result, then settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // registers are written only with the block drained
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [19:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_STEP_TIME)
            dt_us = val;
        else
            wb_mm = val[15:0];
        n_cfg++;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_steer();
        // mostly in range, sometimes anywhere in 16 bits to hit saturation
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_defaults();
        send_item(16'sd1000, 16'sd0);
        send_item(16'sd1000, 16'sd4000);
        send_item(-16'sd1000, -16'sd4000);
        send_item(16'sd0, 16'sd16384);
        drain();
    endtask

    task automatic test_field_extremes();
        send_item(16'h7FFF, 16'sd16384);
        send_item(16'h8000, -16'sd16384);
        send_item(16'h7FFF, 16'h7FFF);     // steering beyond one radian
        send_item(16'h8000, 16'h8000);
        send_item(16'h7FFF, 16'sd16385);
        send_item(16'hFFFF, -16'sd16385);
        send_item(16'h0001, 16'hFFFF);
        send_item(16'h5555, 16'hAAAA);
        send_item(16'hAAAA, 16'h5555);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_STEP_TIME, 20'd0);   // no motion at all
        send_item(16'h7FFF, 16'sd16384);
        send_item(16'h8000, -16'sd9000);
        drain();
        write_reg(REG_STEP_TIME, 20'hFFFFF);
        write_reg(REG_WHEELBASE, 20'd0);   // zero wheelbase acts as 1 mm
        send_item(16'h7FFF, 16'sd16384);
        send_item(16'h8000, 16'sd1);
        send_item(16'h7FFF, -16'sd16384);
        drain();
        write_reg(REG_WHEELBASE, 20'd65535);
        write_reg(REG_STEP_TIME, 20'd1);
        send_item(16'h7FFF, 16'sd16384);
        drain();
        write_reg(REG_WHEELBASE, 20'd100);
        write_reg(REG_STEP_TIME, 20'd1000000);
        // sweep the heading all the way round so it wraps and the quaternion flips
        for (int i = 0; i < 8; i++)
            send_item(16'h7FFF, 16'sd16384);
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(REG_STEP_TIME, DT_RESET);
        write_reg(REG_WHEELBASE, 20'(WB_RESET));
        hold_reqs++;
        for (int i = 0; i < 10; i++)
            send_item(16'($urandom), rand_steer());
        drain();
    endtask

    task automatic test_random();
        int left;
        int phase_len;
        left = N_RANDOM;
        while (left > 0)
        begin
            case ($urandom_range(0, 5))
                0:       write_reg(REG_STEP_TIME, 20'($urandom));
                1:       write_reg(REG_STEP_TIME, 20'($urandom_range(1, 1000000)));
                default: write_reg(REG_STEP_TIME, 20'($urandom_range(1000, 100000)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(REG_WHEELBASE, 20'($urandom_range(0, 65535)));
                1:       write_reg(REG_WHEELBASE, 20'd100);
                default: write_reg(REG_WHEELBASE, 20'($urandom_range(100, 5000)));
            endcase
            phase_len = $urandom_range(50, 250);
            for (int i = 0; i < phase_len && left > 0; i++, left--)
                send_item(16'($urandom), rand_steer());
            drain();
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        n_errors   = 0;
        n_sent     = 0;
        n_checked  = 0;
        n_cfg      = 0;
        cycle_cnt  = 0;
        hold_reqs  = 0;
        burst_left = 0;
        dt_us      = DT_RESET;
        wb_mm      = WB_RESET;
        pose_x     = 0;
        pose_y     = 0;
        pose_h     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_field_extremes();
        test_register_extremes();
        test_backpressure();
        test_random();

        $display("Covered %0d items and %0d register writes; %0d results checked.",
                 n_sent, n_cfg, n_checked);
        $display("Extremes of speed, steering, time step and wheelbase, with heading wrap.");
        if (n_errors == 0 && pose_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: bicycle_model_dead_reckoning.f
rtl/bmdr_pkg.sv
rtl/bmdr_cordic.sv
rtl/bmdr_div.sv
rtl/bicycle_model_dead_reckoning.sv
bench/tb_top.sv
